>>> hdl/bsc_pkg.sv
package bsc_pkg;

  localparam int CHAN_W    = 16;
  localparam int PCT_W     = 7;
  localparam int NUM_CHAN  = 3;
  localparam int NUM_KINDS = 3;
  localparam int NUM_LANES = NUM_CHAN * NUM_KINDS;
  localparam int CFG_IDX_W = 2;

  localparam logic [CHAN_W-1:0] FULL_SCALE = 16'hFFFF;

  // threshold reset values
  localparam logic [CHAN_W-1:0] DARK_RST = 16'd9830;
  localparam logic [CHAN_W-1:0] LITE_RST = 16'd50461;
  localparam logic [CHAN_W-1:0] FG_RST   = 16'd22937;

  // shade percentages
  localparam logic [PCT_W-1:0] PCT_SEL        = 7'd15;
  localparam logic [PCT_W-1:0] PCT_DARK_BOT   = 7'd30;
  localparam logic [PCT_W-1:0] PCT_DARK_TOP   = 7'd50;
  localparam logic [PCT_W-1:0] PCT_LITE_BOT   = 7'd45;
  localparam logic [PCT_W-1:0] PCT_LITE_TOP   = 7'd20;
  localparam logic [PCT_W-1:0] PCT_MED_BOT    = 7'd60;
  localparam logic [PCT_W-1:0] PCT_MED_TOP    = 7'd40;

  // reciprocals: x/3 = (x*RECIP_3)>>20 for x < 2^19,
  // x/100 = (x*RECIP_100)>>30 for x < 2^23
  localparam logic [18:0] RECIP_3   = 19'd349526;
  localparam logic [23:0] RECIP_100 = 24'd10737419;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DARK = 2'd0,
    REG_LITE = 2'd1,
    REG_FG   = 2'd2
  } bsc_reg_e;

  typedef enum logic [1:0] {
    CLS_DARK,
    CLS_LITE,
    CLS_MEDIUM
  } bsc_class_e;

  typedef struct packed {
    logic [CHAN_W-1:0] bg_red;
    logic [CHAN_W-1:0] bg_green;
    logic [CHAN_W-1:0] bg_blue;
  } bsc_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] fg_red;
    logic [CHAN_W-1:0] fg_green;
    logic [CHAN_W-1:0] fg_blue;
    logic [CHAN_W-1:0] sel_red;
    logic [CHAN_W-1:0] sel_green;
    logic [CHAN_W-1:0] sel_blue;
    logic [CHAN_W-1:0] bottom_red;
    logic [CHAN_W-1:0] bottom_green;
    logic [CHAN_W-1:0] bottom_blue;
    logic [CHAN_W-1:0] top_red;
    logic [CHAN_W-1:0] top_green;
    logic [CHAN_W-1:0] top_blue;
  } bsc_out_t;

  typedef struct packed {
    logic [CHAN_W-1:0] dark_thr;
    logic [CHAN_W-1:0] lite_thr;
    logic [CHAN_W-1:0] fg_thr;
  } bsc_cfg_t;

  // one classified word: channels, foreground colour, per-kind percentage and direction
  typedef struct packed {
    logic [NUM_CHAN-1:0][CHAN_W-1:0] ch;
    logic                            fg_black;
    logic [NUM_KINDS-1:0][PCT_W-1:0] pct;
    logic [NUM_KINDS-1:0]            lgt;
  } bsc_job_t;

endpackage

>>> hdl/bsc_front.sv
module bsc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bsc_pkg::bsc_in_t  in_data_i,
  input  bsc_pkg::bsc_cfg_t cfg_i,
  input  logic              full_i,
  output logic              push_o,
  output bsc_pkg::bsc_job_t job_o
);
  import bsc_pkg::*;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  logic [NUM_CHAN-1:0][CHAN_W-1:0] ch1_q, ch2_q, ch3_q, ch4_q, ch5_q;
  logic [17:0] sum1_q;
  logic [22:0] wsum1_q;
  logic [CHAN_W-1:0] inten2_q, lum2_q;
  logic [22:0] bnum3_q;
  logic [CHAN_W-1:0] br4_q, br5_q;
  logic [PCT_W-1:0] pb5_q, pt5_q;

  logic [36:0] inten_prod;
  logic [46:0] lum_prod;
  logic [46:0] br_prod;
  logic [20:0] x25, x30;
  logic [21:0] y25, y30;

  bsc_class_e cls;

  // hold the whole front when the last stage cannot hand off
  assign en         = !(v5_q && full_i);
  assign in_stall_o = !en;
  assign push_o     = v5_q && !full_i;

  assign inten_prod = 37'(sum1_q) * 37'(RECIP_3);
  assign lum_prod   = 47'(wsum1_q) * 47'(RECIP_100);
  assign br_prod    = 47'(bnum3_q) * 47'(RECIP_100);

  // x/65535 = (x + (x>>16) + 1) >> 16 for these small quotients
  assign x25 = 21'(br4_q) * 21'd25;
  assign x30 = 21'(br4_q) * 21'd30;
  assign y25 = 22'(x25) + 22'(x25[20:16]) + 22'd1;
  assign y30 = 22'(x30) + 22'(x30[20:16]) + 22'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ch1_q   <= {in_data_i.bg_red, in_data_i.bg_green, in_data_i.bg_blue};
      sum1_q  <= 18'(in_data_i.bg_red) + 18'(in_data_i.bg_green)
               + 18'(in_data_i.bg_blue);
      wsum1_q <= 23'(in_data_i.bg_red) * 23'd30 + 23'(in_data_i.bg_green) * 23'd59
               + 23'(in_data_i.bg_blue) * 23'd11;

      ch2_q    <= ch1_q;
      inten2_q <= inten_prod[35:20];
      lum2_q   <= lum_prod[45:30];

      ch3_q   <= ch2_q;
      bnum3_q <= 23'(inten2_q) * 23'd25 + 23'(lum2_q) * 23'd75;

      ch4_q <= ch3_q;
      br4_q <= br_prod[45:30];

      ch5_q <= ch4_q;
      br5_q <= br4_q;
      pb5_q <= PCT_MED_BOT - 7'(y25[21:16]);
      pt5_q <= PCT_MED_TOP + 7'(y30[21:16]);
    end
  end

  // classify: dark test first, then light, anything else is medium
  always_comb begin
    if (br5_q < cfg_i.dark_thr) begin
      cls = CLS_DARK;
    end else if (br5_q > cfg_i.lite_thr) begin
      cls = CLS_LITE;
    end else begin
      cls = CLS_MEDIUM;
    end
  end

  always_comb begin
    job_o.ch = ch5_q;
    case (cls)
      CLS_DARK: begin
        job_o.fg_black = 1'b0;
        job_o.pct      = {PCT_DARK_TOP, PCT_DARK_BOT, PCT_SEL};
        job_o.lgt      = 3'b111;
      end
      CLS_LITE: begin
        job_o.fg_black = 1'b1;
        job_o.pct      = {PCT_LITE_TOP, PCT_LITE_BOT, PCT_SEL};
        job_o.lgt      = 3'b000;
      end
      default: begin
        job_o.fg_black = br5_q > cfg_i.fg_thr;
        job_o.pct      = {pt5_q, pb5_q, PCT_SEL};
        job_o.lgt      = 3'b100;
      end
    endcase
  end

endmodule

>>> hdl/bsc_queue.sv
module bsc_queue #(
  parameter int Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bsc_pkg::bsc_job_t wdata_i,
  input  logic              pop_i,
  output bsc_pkg::bsc_job_t rdata_o,
  output logic              full_o,
  output logic              empty_o
);
  import bsc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  bsc_job_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

>>> hdl/bsc_back.sv
module bsc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsc_pkg::bsc_job_t job_i,
  input  logic              avail_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bsc_pkg::bsc_out_t out_data_o
);
  import bsc_pkg::*;

  logic en;
  logic v1_q, v2_q, v3_q;
  logic fg1_q, fg2_q, fg3_q;

  logic [NUM_LANES-1:0][22:0]       prod1_q;
  logic [NUM_LANES-1:0][CHAN_W-1:0] c1_q, c2_q, res3_q, quo2_q;
  logic [NUM_LANES-1:0]             lgt1_q, lgt2_q;

  assign en          = !(v3_q && out_stall_i);
  assign pop_o       = en && avail_i;
  assign out_valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= avail_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fg1_q <= job_i.fg_black;
      fg2_q <= fg1_q;
      fg3_q <= fg2_q;
    end
  end

  // lane k: shade kind k/3 (select, bottom, top), channel k%3 (red, green, blue)
  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    localparam int Kind = k / NUM_CHAN;
    localparam int Chan = k % NUM_CHAN;

    logic [CHAN_W-1:0] c;
    logic [CHAN_W-1:0] base;
    logic [46:0]       quo_prod;

    assign c        = job_i.ch[NUM_CHAN-1-Chan];
    // lighten works on the headroom, darken on the value itself
    assign base     = job_i.lgt[Kind] ? (FULL_SCALE - c) : c;
    assign quo_prod = 47'(prod1_q[k]) * 47'(RECIP_100);

    always_ff @(posedge clk_i) begin
      if (en) begin
        prod1_q[k] <= 23'(base) * 23'(job_i.pct[Kind]);
        c1_q[k]    <= c;
        lgt1_q[k]  <= job_i.lgt[Kind];

        quo2_q[k] <= quo_prod[45:30];
        c2_q[k]   <= c1_q[k];
        lgt2_q[k] <= lgt1_q[k];

        res3_q[k] <= lgt2_q[k] ? (c2_q[k] + quo2_q[k]) : (c2_q[k] - quo2_q[k]);
      end
    end
  end

  always_comb begin
    out_data_o.fg_red       = fg3_q ? '0 : FULL_SCALE;
    out_data_o.fg_green     = fg3_q ? '0 : FULL_SCALE;
    out_data_o.fg_blue      = fg3_q ? '0 : FULL_SCALE;
    out_data_o.sel_red      = res3_q[0];
    out_data_o.sel_green    = res3_q[1];
    out_data_o.sel_blue     = res3_q[2];
    out_data_o.bottom_red   = res3_q[3];
    out_data_o.bottom_green = res3_q[4];
    out_data_o.bottom_blue  = res3_q[5];
    out_data_o.top_red      = res3_q[6];
    out_data_o.top_green    = res3_q[7];
    out_data_o.top_blue     = res3_q[8];
  end

endmodule

>>> hdl/bevel_shadow_color_derivation.sv
// Channel  Dir  Handshake                 Word
// in       in   in_valid_i / in_stall_o   bsc_in_t: background r, g, b
// out      out  out_valid_o / out_stall_i bsc_out_t: fg, select, bottom, top
// cfg      in   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i (threshold)
//
// One word per cycle unless the input is stalled; a result passes through 5 front
// stages for brightness and class, one queue slot and 3 back stages.
// Reset clears the pipeline valids and the queue and loads the default thresholds.
// A stalled output holds the back stages; the queue absorbs up to QueueDepth
// words before the front stalls its input.
module bevel_shadow_color_derivation #(
  parameter int QueueDepth = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  bsc_pkg::bsc_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output bsc_pkg::bsc_out_t                out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bsc_pkg::CHAN_W-1:0]       cfg_data_i
);
  import bsc_pkg::*;

  bsc_cfg_t cfg_q;
  bsc_job_t push_job, pop_job;
  logic     q_push, q_pop, q_full, q_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dark_thr <= DARK_RST;
      cfg_q.lite_thr <= LITE_RST;
      cfg_q.fg_thr   <= FG_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DARK: cfg_q.dark_thr <= cfg_data_i;
        REG_LITE: cfg_q.lite_thr <= cfg_data_i;
        REG_FG:   cfg_q.fg_thr   <= cfg_data_i;
        default: ;  // drop writes past the last register
      endcase
    end
  end

  bsc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .full_i     (q_full),
    .push_o     (q_push),
    .job_o      (push_job)
  );

  bsc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (push_job),
    .pop_i   (q_pop),
    .rdata_o (pop_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  bsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .avail_i     (!q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty))
    else $error("queue read while empty");

  a_fg_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.fg_red == out_data_o.fg_green) &&
                    (out_data_o.fg_red == out_data_o.fg_blue) &&
                    ((out_data_o.fg_red == '0) || (out_data_o.fg_red == FULL_SCALE)))
    else $error("foreground not black or white");

  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_full)
    else $error("input stalled with room in the queue");

endmodule
